// ----- src/ycg_pkg.sv -----
// ----------------------------------------------------------------------------
// ycg_pkg
// Types and constants shared by the yuv color gain filter.
// ----------------------------------------------------------------------------
package ycg_pkg;

  // pixel request into the block
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } ycg_in_t;

  // pixel request out of the block
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } ycg_out_t;

  // configuration register indexes
  localparam logic [1:0] CFG_LUMA_GAIN      = 2'd0;
  localparam logic [1:0] CFG_BLUE_DIFF_GAIN = 2'd1;
  localparam logic [1:0] CFG_RED_DIFF_GAIN  = 2'd2;

  localparam logic [7:0] GAIN_RESET = 8'd128;

  // arithmetic width of the matrix sums
  localparam int SumW = 20;

  // forward matrix
  localparam logic signed [SumW-1:0] K_YR = 20'sd66;
  localparam logic signed [SumW-1:0] K_YG = 20'sd129;
  localparam logic signed [SumW-1:0] K_YB = 20'sd25;
  localparam logic signed [SumW-1:0] K_UR = -20'sd38;
  localparam logic signed [SumW-1:0] K_UG = -20'sd74;
  localparam logic signed [SumW-1:0] K_UB = 20'sd112;
  localparam logic signed [SumW-1:0] K_VR = 20'sd122;
  localparam logic signed [SumW-1:0] K_VG = -20'sd94;
  localparam logic signed [SumW-1:0] K_VB = -20'sd18;

  // inverse matrix
  localparam logic signed [SumW-1:0] K_C   = 20'sd298;
  localparam logic signed [SumW-1:0] K_RE  = 20'sd409;
  localparam logic signed [SumW-1:0] K_GD  = -20'sd100;
  localparam logic signed [SumW-1:0] K_GE  = -20'sd208;
  localparam logic signed [SumW-1:0] K_BD  = 20'sd516;

  localparam logic signed [SumW-1:0] ROUND_HALF = 20'sd128;
  localparam logic [7:0] Y_OFFSET = 8'd16;
  localparam logic [7:0] C_OFFSET = 8'd128;

endpackage

// ----- src/yuv_color_gain_filter_top.sv -----
// throughput: one pixel per cycle unless out_ready stalls the output, four
//   registered stages (forward matrix, gain multiply, inverse matrix, shift
//   and clamp)
// reset: rst synchronous active high, clears all stage valid bits and sets
//   the three gains to 128 (unity)
// ----------------------------------------------------------------------------
// yuv_color_gain_filter_top
// RGB to YUV, per-channel gain with 8-bit wrap, YUV back to RGB with clamp.
// ----------------------------------------------------------------------------
module yuv_color_gain_filter_top
  import ycg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ycg_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output ycg_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] luma_gain;
  logic [7:0] blue_diff_gain;
  logic [7:0] red_diff_gain;

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  logic [7:0] y1, u1, v1_chan;
  logic [7:0] ys2, us2, vs2;
  logic signed [SumW-1:0] sr3, sg3, sb3;

  logic signed [SumW-1:0] r_ext, g_ext, b_ext;
  logic signed [SumW-1:0] y_sum, u_sum, v_sum;
  logic signed [SumW-1:0] y_sh, u_sh, v_sh;
  logic [15:0] y_prod, u_prod, v_prod;
  logic signed [SumW-1:0] c_ext, d_ext, e_ext;
  logic signed [SumW-1:0] r_sum, g_sum, b_sum;
  logic signed [SumW-1:0] r_sh, g_sh, b_sh;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_gain      <= GAIN_RESET;
      blue_diff_gain <= GAIN_RESET;
      red_diff_gain  <= GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LUMA_GAIN:      luma_gain      <= cfg_data;
        CFG_BLUE_DIFF_GAIN: blue_diff_gain <= cfg_data;
        CFG_RED_DIFF_GAIN:  red_diff_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage advance, back from the output
  assign adv4 = !v4 || out_ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // stage 1: forward matrix with rounding and offsets
  always_comb begin
    r_ext = SumW'($unsigned(in_data.red_in));
    g_ext = SumW'($unsigned(in_data.green_in));
    b_ext = SumW'($unsigned(in_data.blue_in));
    y_sum = K_YR * r_ext + K_YG * g_ext + K_YB * b_ext + ROUND_HALF;
    u_sum = K_UR * r_ext + K_UG * g_ext + K_UB * b_ext + ROUND_HALF;
    v_sum = K_VR * r_ext + K_VG * g_ext + K_VB * b_ext + ROUND_HALF;
    y_sh  = y_sum >>> 8;
    u_sh  = u_sum >>> 8;
    v_sh  = v_sum >>> 8;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      y1      <= y_sh[7:0] + Y_OFFSET;
      u1      <= u_sh[7:0] + C_OFFSET;
      v1_chan <= v_sh[7:0] + C_OFFSET;
    end
  end

  // stage 2: gain, keep low 8 bits after the shift by 7
  assign y_prod = y1 * luma_gain;
  assign u_prod = u1 * blue_diff_gain;
  assign v_prod = v1_chan * red_diff_gain;

  always_ff @(posedge clk) begin
    if (adv2) begin
      ys2 <= y_prod[14:7];
      us2 <= u_prod[14:7];
      vs2 <= v_prod[14:7];
    end
  end

  // stage 3: inverse matrix sums
  always_comb begin
    c_ext = SumW'($unsigned(ys2)) - SumW'($unsigned(Y_OFFSET));
    d_ext = SumW'($unsigned(us2)) - SumW'($unsigned(C_OFFSET));
    e_ext = SumW'($unsigned(vs2)) - SumW'($unsigned(C_OFFSET));
    r_sum = K_C * c_ext + K_RE * e_ext + ROUND_HALF;
    g_sum = K_C * c_ext + K_GD * d_ext + K_GE * e_ext + ROUND_HALF;
    b_sum = K_C * c_ext + K_BD * d_ext + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      sr3 <= r_sum;
      sg3 <= g_sum;
      sb3 <= b_sum;
    end
  end

  // stage 4: floor shift and clamp to 0..255
  function automatic logic [7:0] clamp8(input logic signed [SumW-1:0] val);
    logic [7:0] res;
    if (val < 0) begin
      res = 8'd0;
    end else if (val > 255) begin
      res = 8'd255;
    end else begin
      res = val[7:0];
    end
    return res;
  endfunction

  assign r_sh = sr3 >>> 8;
  assign g_sh = sg3 >>> 8;
  assign b_sh = sb3 >>> 8;

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_data.red_out   <= clamp8(r_sh);
      out_data.green_out <= clamp8(g_sh);
      out_data.blue_out  <= clamp8(b_sh);
    end
  end

  assign out_valid = v4;

  // checks
  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    v1 && !adv2 |=> v1 && $stable(y1) && $stable(u1))
    else $error("stage 1 lost data on stall");

  a_stall_holds_s3: assert property (@(posedge clk) disable iff (rst)
    v3 && !adv4 |=> v3 && $stable(sr3) && $stable(sg3) && $stable(sb3))
    else $error("stage 3 lost data on stall");

  a_no_ready_when_full: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && v4 && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is full and stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !v1)
    else $error("pipeline not empty after reset");

endmodule

// ----- tb/sv/yuv_color_gain_filter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_color_gain_filter_top_tb
// Drives RGB pixels through the color gain filter under random idling and
// backpressure, predicts each result in the bench with its own copy of the
// three gain registers, and compares every output pixel channel by channel.
// ----------------------------------------------------------------------------
module yuv_color_gain_filter_top_tb;
  import ycg_pkg::*;

  // register index the block does not decode
  localparam logic [1:0] CFG_SPARE = 2'd3;
  // cycles without any accepted request before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  ycg_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  ycg_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // bench copy of the gain registers
  logic [7:0] gain_y = GAIN_RESET;
  logic [7:0] gain_u = GAIN_RESET;
  logic [7:0] gain_v = GAIN_RESET;

  ycg_out_t   pending_pixels[$];
  ycg_out_t   want;
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  bit         no_idle = 1'b0;
  bit         hold_req = 1'b0;

  yuv_color_gain_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // 8-bit gain in units of 1/128, product wraps to 8 bits
  function automatic int scale_chan(int chan, logic [7:0] gain);
    return (((chan & 255) * int'(gain)) >> 7) & 255;
  endfunction

  function automatic logic [7:0] clamp_byte(int val);
    if (val < 0) return 8'd0;
    if (val > 255) return 8'd255;
    return val[7:0];
  endfunction

  // rgb -> yuv, per-channel gain, yuv -> rgb with floor shifts and clamp
  function automatic ycg_out_t gain_filter_pixel(ycg_in_t px);
    int r, g, b, y, u, v, c, d, e;
    ycg_out_t res;
    r = int'(px.red_in);
    g = int'(px.green_in);
    b = int'(px.blue_in);
    y = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
    u = ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
    v = ((122 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
    c = scale_chan(y, gain_y) - 16;
    d = scale_chan(u, gain_u) - 128;
    e = scale_chan(v, gain_v) - 128;
    res.red_out   = clamp_byte((298 * c + 409 * e + 128) >>> 8);
    res.green_out = clamp_byte((298 * c - 100 * d - 208 * e + 128) >>> 8);
    res.blue_out  = clamp_byte((298 * c + 516 * d + 128) >>> 8);
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
    $display("[%0t] mismatch %s: got %0d, predicted %0d", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  // track config writes, predict accepted pixels, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LUMA_GAIN:      gain_y = cfg_data;
          CFG_BLUE_DIFF_GAIN: gain_u = cfg_data;
          CFG_RED_DIFF_GAIN:  gain_v = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_pixels.push_back(gain_filter_pixel(in_data));
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $display("[%0t] output request with no pixel pending", $realtime);
          mismatch_count++;
        end else begin
          want = pending_pixels.pop_front();
          if (out_data.red_out !== want.red_out)
            report_mismatch("red_out", out_data.red_out, want.red_out);
          if (out_data.green_out !== want.green_out)
            report_mismatch("green_out", out_data.green_out, want.green_out);
          if (out_data.blue_out !== want.blue_out)
            report_mismatch("blue_out", out_data.blue_out, want.blue_out);
        end
      end
    end
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL yuv_color_gain_filter_top");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  // output side: random gaps, plus one long hold-off on request
  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = idle_cycles();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && !hold_req);
    end
  end

  // valid stays high on return so back-to-back requests never toggle it
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{red_in: r, green_in: g, blue_in: b};
    do @(posedge clk); while (!in_ready);
  endtask

  // deassert valid and let the checker queue the last accepted pixel before polling
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_gains(input logic [7:0] yg, input logic [7:0] ug, input logic [7:0] vg);
    wait_drained();
    write_reg(CFG_LUMA_GAIN, yg);
    write_reg(CFG_BLUE_DIFF_GAIN, ug);
    write_reg(CFG_RED_DIFF_GAIN, vg);
    cfg_valid <= 1'b0;
  endtask

  // channel biased toward the extremes
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return GAIN_RESET;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // unity gains out of reset: corners and alternating bit patterns
  task automatic test_reset_gains();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
  endtask

  // wrapping gain products, zero gains with negative sums, unused index
  task automatic test_gain_extremes();
    set_gains(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    set_gains(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    set_gains(8'd64, 8'd200, 8'd30);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd40, 8'd90);
    // a write to the unused index must leave all gains alone
    wait_drained();
    write_reg(CFG_SPARE, 8'h5A);
    cfg_valid <= 1'b0;
    send_pixel(8'd17, 8'd230, 8'd99);
    send_pixel(8'd255, 8'd128, 8'd0);
  endtask

  // random pixels over several gain settings, some phases without idling
  task automatic test_random_stream();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       set_gains(GAIN_RESET, GAIN_RESET, GAIN_RESET);
        1:       set_gains(8'd255, 8'd255, 8'd255);
        2:       set_gains(8'd0, 8'd0, 8'd0);
        default: set_gains(rand_gain(), rand_gain(), rand_gain());
      endcase
      no_idle = (phase % 4 == 3);
      repeat (225) send_pixel(rand_chan(), rand_chan(), rand_chan());
    end
    no_idle = 1'b0;
  endtask

  // long receiver hold-off with the sender streaming, then a full drain and more pixels
  task automatic test_backpressure();
    set_gains(rand_gain(), rand_gain(), rand_gain());
    hold_req = 1'b1;
    no_idle = 1'b1;
    repeat (60) send_pixel(rand_chan(), rand_chan(), rand_chan());
    no_idle = 1'b0;
    wait_drained();
    repeat (40) send_pixel(rand_chan(), rand_chan(), rand_chan());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_gains();
    test_gain_extremes();
    test_random_stream();
    test_backpressure();
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS yuv_color_gain_filter_top");
    else
      $display("FAIL yuv_color_gain_filter_top");
    $finish;
  end

endmodule
